@@ rtl/core/bcg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge package
// Shared types, codes and the constant threshold and anchor tables.
// ----------------------------------------------------------------------------
package bcg_pkg;

    // Width of the part of an ADC word that is used.
    localparam int SAMPLE_BITS = 16;

    // Item codes carried on func.
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_PINS   = 2'd1,
        OP_POLL   = 2'd2,
        OP_QUERY  = 2'd3
    } bcg_op_t;

    // Charger state codes.
    localparam logic [1:0] CHG_CHARGING    = 2'd0;
    localparam logic [1:0] CHG_FULL        = 2'd1;
    localparam logic [1:0] CHG_DISCHARGING = 2'd2;
    localparam logic [1:0] CHG_MISSING     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW_SAMPLES   = 2'd0;
    localparam logic [1:0] REG_LOW_DOMAIN_LIMIT = 2'd1;
    localparam logic [1:0] REG_SNAP_THRESHOLD   = 2'd2;
    localparam logic [1:0] REG_STEP_SIZE        = 2'd3;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_LVL_SETUP,
        ST_LVL_DIV,
        ST_FINISH
    } bcg_state_t;

    // One classified word as held in the queue; pin levels already inverted.
    typedef struct packed {
        bcg_op_t     op;
        logic [15:0] sample;
        logic        supply_ok;
        logic        charging;
    } bcg_word_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        bcg_word_t word;
    } bcg_queue_out_t;

    // Threshold tables: sel[1] high domain, sel[0] charging context.
    function automatic logic [15:0] bcg_table(input logic [1:0] sel, input logic [2:0] k);
        logic [15:0] v;
        v = 16'h0000;
        case (sel)
            2'd0:
            begin
                case (k)
                    3'd0: v = 16'h29a5;
                    3'd1: v = 16'h29c5;
                    3'd2: v = 16'h2cb5;
                    3'd3: v = 16'h2dcf;
                    3'd4: v = 16'h2f86;
                    default: v = 16'h0000;
                endcase
            end
            2'd1:
            begin
                case (k)
                    3'd0: v = 16'h2a62;
                    3'd1: v = 16'h2a81;
                    3'd2: v = 16'h2d71;
                    3'd3: v = 16'h2e8c;
                    3'd4: v = 16'h3043;
                    default: v = 16'h0000;
                endcase
            end
            2'd2:
            begin
                case (k)
                    3'd0: v = 16'h8f28;
                    3'd1: v = 16'h8f94;
                    3'd2: v = 16'h99af;
                    3'd3: v = 16'h9d79;
                    3'd4: v = 16'ha35e;
                    default: v = 16'h0000;
                endcase
            end
            default:
            begin
                case (k)
                    3'd0: v = 16'h95e5;
                    3'd1: v = 16'h9651;
                    3'd2: v = 16'ha06c;
                    3'd3: v = 16'ha436;
                    3'd4: v = 16'haa1b;
                    default: v = 16'h0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // Percent anchors of the piecewise-linear curve.
    function automatic logic [6:0] bcg_anchor(input logic [2:0] k);
        logic [6:0] v;
        case (k)
            3'd0: v = 7'd0;
            3'd1: v = 7'd1;
            3'd2: v = 7'd6;
            3'd3: v = 7'd18;
            3'd4: v = 7'd45;
            3'd5: v = 7'd100;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // Charger state from active-high power good and charging flags.
    function automatic logic [1:0] bcg_charger_state(input logic pg, input logic ch);
        logic [1:0] v;
        if (pg)
        begin
            v = ch ? CHG_CHARGING : CHG_FULL;
        end
        else
        begin
            v = ch ? CHG_MISSING : CHG_DISCHARGING;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bcg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge front end
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bcg_front
    import bcg_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     func,
    input  wire logic [15:0]    adc_sample,
    input  wire logic           pgood_pin,
    input  wire logic           chg_pin,
    output bcg_queue_out_t      q_out,
    input  wire logic           q_pop
);

    bcg_word_t  q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    bcg_word_t  word_in;

    // Classify the incoming word: decode the code, keep the used sample bits
    // and turn the active-low pins into active-high flags.
    always_comb
    begin
        word_in.op        = bcg_op_t'(func);
        word_in.sample    = 16'(adc_sample[SAMPLE_BITS-1:0]);
        word_in.supply_ok = ~pgood_pin;
        word_in.charging  = ~chg_pin;
    end

    // The queue stalls the sender only when both entries are taken.
    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.word  = q_mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/bcg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge back end
// Carries out queued words: window averaging, floor tracking, interpolation
// through a shared iterative divider, UI slewing and the result register.
// ----------------------------------------------------------------------------
module bcg_back
    import bcg_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bcg_queue_out_t q_out,
    output logic                q_pop,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [1:0]          charger_state,
    output logic [6:0]          level_percent,
    output logic [6:0]          ui_percent,
    output logic [15:0]         floor_value,
    output logic [15:0]         window_average,
    output logic                restart_conversion,
    output logic                stop_conversion
);

    // Sequencer and configuration.
    bcg_state_t  state_reg, state_next;
    logic [3:0]  win_reg, win_next;
    logic [15:0] limit_reg, limit_next;
    logic [6:0]  snap_reg, snap_next;
    logic [6:0]  step_reg, step_next;

    // Gauge state.
    logic        supply_ok_reg, supply_ok_next;
    logic        charging_reg, charging_next;
    logic        settle_reg, settle_next;
    logic        rst_pend_reg, rst_pend_next;
    logic        avg_valid_reg, avg_valid_next;
    logic [3:0]  count_reg, count_next;
    logic [19:0] sum_reg, sum_next;
    logic [15:0] raw_avg_reg, raw_avg_next;
    logic [15:0] floor_reg, floor_next;
    logic        ui_init_reg, ui_init_next;
    logic [1:0]  ui_state_reg, ui_state_next;
    logic [6:0]  ui_level_reg, ui_level_next;

    // Item in progress.
    bcg_op_t     op_reg, op_next;
    logic        restart_reg, restart_next;
    logic        stop_reg, stop_next;
    logic [6:0]  base_reg, base_next;
    logic [6:0]  level_reg, level_next;

    // Shared divider.
    logic [15:0] div_rem_reg, div_rem_next;
    logic [15:0] div_quo_reg, div_quo_next;
    logic [15:0] div_den_reg, div_den_next;
    logic [4:0]  div_left_reg, div_left_next;
    logic [16:0] div_part;
    logic [17:0] div_diff;
    logic        div_geq;
    logic [15:0] div_rem_step;
    logic [15:0] div_quo_step;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_state_reg, out_state_next;
    logic [6:0]  out_level_reg, out_level_next;
    logic [6:0]  out_ui_reg, out_ui_next;
    logic [15:0] out_floor_reg, out_floor_next;
    logic [15:0] out_avg_reg, out_avg_next;
    logic        out_restart_reg, out_restart_next;
    logic        out_stop_reg, out_stop_next;

    // Combinational helpers.
    logic        slot_free;
    logic        cfg_wr;
    logic [3:0]  win_eff;
    logic [19:0] sum_acc;
    logic [3:0]  count_inc;
    logic [1:0]  st_now;
    logic [1:0]  tsel;
    logic [15:0] t_first, t_second, t_third, t_fourth, t_last;
    logic [1:0]  seg;
    logic [15:0] seg_lo, seg_hi, span, offset;
    logic [6:0]  seg_lp, seg_hp;
    logic [5:0]  gap;
    logic [21:0] product;
    logic [15:0] avg_new;
    logic signed [8:0] delta, snap_s, step_s, slew;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || !out_stall;

    // One restoring division step: a quotient bit per cycle.
    assign div_part     = {div_rem_reg, div_quo_reg[15]};
    assign div_diff     = {1'b0, div_part} - {2'b00, div_den_reg};
    assign div_geq      = !div_diff[17];
    assign div_rem_step = div_geq ? div_diff[15:0] : div_part[15:0];
    assign div_quo_step = {div_quo_reg[14:0], div_geq};

    // Window bookkeeping for a kept sample.
    assign win_eff   = (win_reg == 4'd0) ? 4'd1 : win_reg;
    assign sum_acc   = sum_reg + 20'(q_out.word.sample);
    assign count_inc = count_reg + 4'd1;
    assign avg_new   = div_quo_step;

    // Table lookup and segment search on the current floor.
    assign st_now   = bcg_charger_state(supply_ok_reg, charging_reg);
    assign tsel     = {(floor_reg >= limit_reg),
                       ((st_now == CHG_CHARGING) || (st_now == CHG_FULL))};
    assign t_first  = bcg_table(tsel, 3'd0);
    assign t_second = bcg_table(tsel, 3'd1);
    assign t_third  = bcg_table(tsel, 3'd2);
    assign t_fourth = bcg_table(tsel, 3'd3);
    assign t_last   = bcg_table(tsel, 3'd4);

    always_comb
    begin
        if (floor_reg <= t_second)
        begin
            seg = 2'd0;
        end
        else if (floor_reg <= t_third)
        begin
            seg = 2'd1;
        end
        else if (floor_reg <= t_fourth)
        begin
            seg = 2'd2;
        end
        else
        begin
            seg = 2'd3;
        end
    end

    assign seg_lo  = bcg_table(tsel, {1'b0, seg});
    assign seg_hi  = bcg_table(tsel, {1'b0, seg} + 3'd1);
    assign seg_lp  = bcg_anchor({1'b0, seg} + 3'd1);
    assign seg_hp  = bcg_anchor({1'b0, seg} + 3'd2);
    assign span    = seg_hi - seg_lo;
    assign offset  = floor_reg - seg_lo;
    assign gap     = 6'(seg_hp - seg_lp);
    assign product = offset * gap;

    // Signed view of the UI step decision.
    assign delta  = $signed({2'b00, level_reg}) - $signed({2'b00, ui_level_reg});
    assign snap_s = $signed({2'b00, snap_reg});
    assign step_s = $signed({2'b00, step_reg});

    // Next state and datapath.
    always_comb
    begin
        state_next       = state_reg;
        win_next         = win_reg;
        limit_next       = limit_reg;
        snap_next        = snap_reg;
        step_next        = step_reg;
        supply_ok_next   = supply_ok_reg;
        charging_next    = charging_reg;
        settle_next      = settle_reg;
        rst_pend_next    = rst_pend_reg;
        avg_valid_next   = avg_valid_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        raw_avg_next     = raw_avg_reg;
        floor_next       = floor_reg;
        ui_init_next     = ui_init_reg;
        ui_state_next    = ui_state_reg;
        ui_level_next    = ui_level_reg;
        op_next          = op_reg;
        restart_next     = restart_reg;
        stop_next        = stop_reg;
        base_next        = base_reg;
        level_next       = level_reg;
        div_rem_next     = div_rem_reg;
        div_quo_next     = div_quo_reg;
        div_den_next     = div_den_reg;
        div_left_next    = div_left_reg;
        out_valid_next   = out_valid_reg;
        out_state_next   = out_state_reg;
        out_level_next   = out_level_reg;
        out_ui_next      = out_ui_reg;
        out_floor_next   = out_floor_reg;
        out_avg_next     = out_avg_reg;
        out_restart_next = out_restart_reg;
        out_stop_next    = out_stop_reg;
        q_pop            = 1'b0;
        slew             = 9'sd0;

        // Configuration writes.
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_WINDOW_SAMPLES:   win_next   = cfg_data[3:0];
                REG_LOW_DOMAIN_LIMIT: limit_next = cfg_data;
                REG_SNAP_THRESHOLD:   snap_next  = cfg_data[6:0];
                REG_STEP_SIZE:        step_next  = cfg_data[6:0];
                default:              win_next   = win_reg;
            endcase
        end

        // A delivered result frees the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_out.valid && slot_free)
                begin
                    q_pop        = 1'b1;
                    op_next      = q_out.word.op;
                    restart_next = 1'b0;
                    stop_next    = 1'b0;
                    state_next   = ST_LVL_SETUP;
                    case (q_out.word.op)
                        OP_SAMPLE:
                        begin
                            if (settle_reg)
                            begin
                                settle_next  = 1'b0;
                                restart_next = 1'b1;
                            end
                            else if (count_inc >= win_eff)
                            begin
                                // Window complete: divide the sum by the count.
                                sum_next      = 20'd0;
                                count_next    = 4'd0;
                                div_rem_next  = {12'd0, sum_acc[19:16]};
                                div_quo_next  = sum_acc[15:0];
                                div_den_next  = {12'd0, count_inc};
                                div_left_next = 5'd16;
                                state_next    = ST_AVG_DIV;
                            end
                            else
                            begin
                                sum_next   = sum_acc;
                                count_next = count_inc;
                            end
                        end
                        OP_PINS:
                        begin
                            if ((q_out.word.supply_ok != supply_ok_reg) ||
                                (q_out.word.charging != charging_reg))
                            begin
                                rst_pend_next = 1'b1;
                            end
                            supply_ok_next = q_out.word.supply_ok;
                            charging_next  = q_out.word.charging;
                        end
                        OP_POLL:
                        begin
                            settle_next = 1'b1;
                        end
                        default:
                        begin
                            settle_next = settle_reg;
                        end
                    endcase
                end
            end

            ST_AVG_DIV:
            begin
                div_rem_next  = div_rem_step;
                div_quo_next  = div_quo_step;
                div_left_next = div_left_reg - 5'd1;
                if (div_left_reg == 5'd1)
                begin
                    // Publish the average and let the floor follow it.
                    raw_avg_next = avg_new;
                    if (!avg_valid_reg || (avg_new <= floor_reg) || rst_pend_reg)
                    begin
                        floor_next = avg_new;
                    end
                    rst_pend_next  = 1'b0;
                    avg_valid_next = 1'b1;
                    stop_next      = 1'b1;
                    state_next     = ST_LVL_SETUP;
                end
            end

            ST_LVL_SETUP:
            begin
                state_next = ST_FINISH;
                if (st_now == CHG_MISSING)
                begin
                    level_next = 7'd0;
                end
                else if (floor_reg <= t_first)
                begin
                    level_next = bcg_anchor(3'd0);
                end
                else if (floor_reg > t_last)
                begin
                    level_next = bcg_anchor(3'd5);
                end
                else if (seg_hi <= seg_lo)
                begin
                    level_next = seg_lp;
                end
                else
                begin
                    // Quotient is below 64, so six steps are enough.
                    base_next     = seg_lp;
                    div_rem_next  = product[21:6];
                    div_quo_next  = {product[5:0], 10'd0};
                    div_den_next  = span;
                    div_left_next = 5'd6;
                    state_next    = ST_LVL_DIV;
                end
            end

            ST_LVL_DIV:
            begin
                div_rem_next  = div_rem_step;
                div_quo_next  = div_quo_step;
                div_left_next = div_left_reg - 5'd1;
                if (div_left_reg == 5'd1)
                begin
                    level_next = base_reg + {1'b0, div_quo_step[5:0]};
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // UI percent update for a query.
                if ((op_reg == OP_QUERY) && avg_valid_reg)
                begin
                    if (!ui_init_reg || (st_now != ui_state_reg))
                    begin
                        ui_init_next  = 1'b1;
                        ui_state_next = st_now;
                        ui_level_next = level_reg;
                    end
                    else if (st_now == CHG_MISSING)
                    begin
                        ui_level_next = 7'd0;
                    end
                    else if (st_now == CHG_FULL)
                    begin
                        ui_level_next = level_reg;
                    end
                    else if ((st_now == CHG_DISCHARGING) && (delta > 9'sd0))
                    begin
                        ui_level_next = ui_level_reg;
                    end
                    else if ((delta >= snap_s) || (delta <= -snap_s))
                    begin
                        ui_level_next = level_reg;
                    end
                    else
                    begin
                        slew = $signed({2'b00, ui_level_reg});
                        if (delta > 9'sd0)
                        begin
                            slew = slew + step_s;
                        end
                        else if (delta < 9'sd0)
                        begin
                            slew = slew - step_s;
                        end
                        if (slew < 9'sd0)
                        begin
                            ui_level_next = 7'd0;
                        end
                        else if (slew > 9'sd100)
                        begin
                            ui_level_next = 7'd100;
                        end
                        else
                        begin
                            ui_level_next = slew[6:0];
                        end
                    end
                end

                // Load the result register.
                out_valid_next   = 1'b1;
                out_state_next   = st_now;
                out_level_next   = level_reg;
                out_ui_next      = ui_level_next;
                out_floor_next   = floor_reg;
                out_avg_next     = raw_avg_reg;
                out_restart_next = restart_reg;
                out_stop_next    = stop_reg;
                state_next       = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and gauge state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_reg        <= 4'd9;
            limit_reg      <= 16'h4000;
            snap_reg       <= 7'd5;
            step_reg       <= 7'd1;
            supply_ok_reg  <= 1'b0;
            charging_reg   <= 1'b0;
            settle_reg     <= 1'b0;
            rst_pend_reg   <= 1'b0;
            avg_valid_reg  <= 1'b0;
            count_reg      <= 4'd0;
            sum_reg        <= 20'd0;
            raw_avg_reg    <= 16'd0;
            floor_reg      <= 16'd0;
            ui_init_reg    <= 1'b0;
            ui_state_reg   <= 2'd0;
            ui_level_reg   <= 7'd0;
            div_left_reg   <= 5'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_reg        <= win_next;
            limit_reg      <= limit_next;
            snap_reg       <= snap_next;
            step_reg       <= step_next;
            supply_ok_reg  <= supply_ok_next;
            charging_reg   <= charging_next;
            settle_reg     <= settle_next;
            rst_pend_reg   <= rst_pend_next;
            avg_valid_reg  <= avg_valid_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            raw_avg_reg    <= raw_avg_next;
            floor_reg      <= floor_next;
            ui_init_reg    <= ui_init_next;
            ui_state_reg   <= ui_state_next;
            ui_level_reg   <= ui_level_next;
            div_left_reg   <= div_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        restart_reg     <= restart_next;
        stop_reg        <= stop_next;
        base_reg        <= base_next;
        level_reg       <= level_next;
        div_rem_reg     <= div_rem_next;
        div_quo_reg     <= div_quo_next;
        div_den_reg     <= div_den_next;
        out_state_reg   <= out_state_next;
        out_level_reg   <= out_level_next;
        out_ui_reg      <= out_ui_next;
        out_floor_reg   <= out_floor_next;
        out_avg_reg     <= out_avg_next;
        out_restart_reg <= out_restart_next;
        out_stop_reg    <= out_stop_next;
    end

    assign out_valid          = out_valid_reg;
    assign charger_state      = out_state_reg;
    assign level_percent      = out_level_reg;
    assign ui_percent         = out_ui_reg;
    assign floor_value        = out_floor_reg;
    assign window_average     = out_avg_reg;
    assign restart_conversion = out_restart_reg;
    assign stop_conversion    = out_stop_reg;

endmodule
`default_nettype wire

@@ rtl/core/battery_charge_gauge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge
// Windowed ADC averaging, floor tracking, charger state and UI percent.
// ----------------------------------------------------------------------------
// Input words (func, adc_sample, pgood_pin, chg_pin) are taken on in_valid
// when in_stall is low; one result word follows every input word, in order,
// on out_valid, and is held while out_stall is high.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while the block is idle.
// A word that needs no division goes from ST_IDLE through ST_LVL_SETUP to
// ST_FINISH; a six-step divide is added when the floor lies inside a table
// segment, and when a sample closes a window a sixteen-step divide of the sum
// by the count comes first, then the interpolation divide if it is needed.
// Both divides share one one-bit-per-cycle restoring divider in the back end,
// and the back end takes a new word only when it has finished the last one.
// A two-word queue separates the front end from the back end, so input words
// keep being taken while a result waits; when the queue is full in_stall rises.
// Reset clears all gauge state, empties the queue and loads the default
// register values; in_stall is low out of reset, so input words are taken at once.
// ----------------------------------------------------------------------------
module battery_charge_gauge
    import bcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] adc_sample,
    input  wire logic        pgood_pin,
    input  wire logic        chg_pin,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       charger_state,
    output logic [6:0]       level_percent,
    output logic [6:0]       ui_percent,
    output logic [15:0]      floor_value,
    output logic [15:0]      window_average,
    output logic             restart_conversion,
    output logic             stop_conversion,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bcg_queue_out_t q_out;
    logic           q_pop;

    // Front end: accept, classify, queue.
    bcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .adc_sample (adc_sample),
        .pgood_pin  (pgood_pin),
        .chg_pin    (chg_pin),
        .q_out      (q_out),
        .q_pop      (q_pop)
    );

    // Back end: execute and deliver results.
    bcg_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_out              (q_out),
        .q_pop              (q_pop),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .charger_state      (charger_state),
        .level_percent      (level_percent),
        .ui_percent         (ui_percent),
        .floor_value        (floor_value),
        .window_average     (window_average),
        .restart_conversion (restart_conversion),
        .stop_conversion    (stop_conversion)
    );

`ifndef SYNTHESIS
    // The back end only takes a word that the queue actually holds.
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_out.valid)
        else $error("queue popped while empty");

    // A discarded settle sample never publishes an average.
    a_restart_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(restart_conversion && stop_conversion))
        else $error("restart and stop in the same result");

    // A missing battery reads as zero percent.
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (charger_state == CHG_MISSING)) |-> (level_percent == 7'd0))
        else $error("nonzero level with battery missing");

    // Percentages stay within range.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((level_percent <= 7'd100) && (ui_percent <= 7'd100)))
        else $error("percent out of range");
`endif

endmodule
`default_nettype wire

@@ verif/tb_battery_charge_gauge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge gauge testbench
// Drives sample, pin, poll and query words into the gauge and checks every
// result word against a cycle-free prediction of the gauge state. A short
// table of directed words comes first, then random bursts, most of them whole
// poll/settle/window/query sequences, under several register settings and
// with random idling on the input side and stalling on the output side.
// ----------------------------------------------------------------------------
module tb_battery_charge_gauge
    import bcg_pkg::*;
();

    // Extra wait after the last expected word has been seen, in cycles.
    localparam int DRAIN_CYCLES = 40;
    localparam int WORDS_PER_PHASE = 72;
    localparam int PHASES = 6;

    // Threshold rows: low discharging, low charging, high discharging, high charging.
    localparam logic [16*20-1:0] THRESH_ROM = {
        16'h29a5, 16'h29c5, 16'h2cb5, 16'h2dcf, 16'h2f86,
        16'h2a62, 16'h2a81, 16'h2d71, 16'h2e8c, 16'h3043,
        16'h8f28, 16'h8f94, 16'h99af, 16'h9d79, 16'ha35e,
        16'h95e5, 16'h9651, 16'ha06c, 16'ha436, 16'haa1b
    };
    localparam logic [7*6-1:0] ANCHOR_ROM = {7'd0, 7'd1, 7'd6, 7'd18, 7'd45, 7'd100};

    typedef struct packed {
        logic [1:0]  chg_state;
        logic [6:0]  level;
        logic [6:0]  ui;
        logic [15:0] floor_lvl;
        logic [15:0] average;
        logic        restart;
        logic        stop;
    } gauge_reading_t;

    typedef struct packed {
        bcg_op_t        op;
        logic [15:0]    smp;
        logic           pg_pin;
        logic           ch_pin;
        logic           typed;
        gauge_reading_t want;
    } gauge_probe_t;

    localparam gauge_reading_t NO_CHECK = '0;
    localparam int PROBE_ROWS = 24;

    // Directed words; the typed rows carry results that follow directly from reset.
    gauge_probe_t probe_table [PROBE_ROWS] = '{
        // Query and poll before any average: levels, floor and average still at zero.
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd0, 16'h0000, 16'h0000, 1'b0, 1'b0}},
        '{OP_POLL,   16'h0000, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd0, 16'h0000, 16'h0000, 1'b0, 1'b0}},
        // The settle sample is thrown away.
        '{OP_SAMPLE, 16'h1234, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd0, 16'h0000, 16'h0000, 1'b1, 1'b0}},
        // Zero window acts as one: full scale publishes and seeds the floor.
        '{OP_SAMPLE, 16'hFFFF, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd100, 7'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd100, 7'd100, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}},
        '{OP_SAMPLE, 16'h0000, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd100, 16'h0000, 16'h0000, 1'b0, 1'b1}},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd0, 16'h0000, 16'h0000, 1'b0, 1'b0}},
        // A higher average may not lift the floor without a pin change.
        '{OP_SAMPLE, 16'h2b00, 1'b1, 1'b1, 1'b1,
          '{CHG_DISCHARGING, 7'd0, 7'd0, 16'h0000, 16'h2b00, 1'b0, 1'b1}},
        '{OP_PINS,   16'h0000, 1'b0, 1'b0, 1'b1,
          '{CHG_CHARGING, 7'd0, 7'd0, 16'h0000, 16'h2b00, 1'b0, 1'b0}},
        '{OP_SAMPLE, 16'h2b00, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_PINS,   16'h0000, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{OP_SAMPLE, 16'h2f00, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_SAMPLE, 16'h2e00, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_PINS,   16'h0000, 1'b1, 1'b0, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_PINS,   16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_SAMPLE, 16'h9a00, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_SAMPLE, 16'h9e00, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_SAMPLE, 16'h9900, 1'b1, 1'b1, 1'b0, NO_CHECK},
        '{OP_QUERY,  16'h0000, 1'b1, 1'b1, 1'b0, NO_CHECK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = OP_SAMPLE;
    logic [15:0] adc_sample = 16'h0000;
    logic        pgood_pin = 1'b1;
    logic        chg_pin = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  charger_state;
    logic [6:0]  level_percent;
    logic [6:0]  ui_percent;
    logic [15:0] floor_value;
    logic [15:0] window_average;
    logic        restart_conversion;
    logic        stop_conversion;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WINDOW_SAMPLES;
    logic [15:0] cfg_data = 16'h0000;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned words_sent = 0;

    gauge_reading_t expected_readings [$];

    // Predicted gauge state and register copies.
    logic [3:0]  cfg_window = 4'd9;
    logic [15:0] cfg_limit = 16'h4000;
    logic [6:0]  cfg_snap = 7'd5;
    logic [6:0]  cfg_step = 7'd1;
    logic        pg_flag = 1'b0;
    logic        ch_flag = 1'b0;
    logic        settle_armed = 1'b0;
    logic        floor_reseed = 1'b0;
    logic        average_seen = 1'b0;
    int unsigned window_count = 0;
    int unsigned window_sum = 0;
    logic [15:0] last_average = 16'h0000;
    logic [15:0] gauge_floor = 16'h0000;
    logic        ui_ready = 1'b0;
    logic [1:0]  ui_mode = 2'd0;
    logic [6:0]  ui_pct = 7'd0;

    battery_charge_gauge dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output stalling is redrawn every cycle.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int unsigned threshold(input int unsigned sel, input int unsigned k);
        return THRESH_ROM[16*(19 - (5*sel + k)) +: 16];
    endfunction

    function automatic int unsigned anchor(input int unsigned k);
        return ANCHOR_ROM[7*(5 - k) +: 7];
    endfunction

    function automatic logic [1:0] charger_now();
        if (pg_flag)
        begin
            return ch_flag ? CHG_CHARGING : CHG_FULL;
        end
        return ch_flag ? CHG_MISSING : CHG_DISCHARGING;
    endfunction

    // Piecewise-linear percent of the floor on the table picked by domain and context.
    function automatic logic [6:0] floor_percent(input logic [1:0] st);
        int unsigned sel, seg, lo, hi, lp, hp, fl;
        if (st == CHG_MISSING)
        begin
            return 7'd0;
        end
        fl = gauge_floor;
        sel = ((fl < cfg_limit) ? 0 : 2) + ((st == CHG_CHARGING || st == CHG_FULL) ? 1 : 0);
        if (fl <= threshold(sel, 0))
        begin
            return 7'(anchor(0));
        end
        if (fl > threshold(sel, 4))
        begin
            return 7'(anchor(5));
        end
        if (fl <= threshold(sel, 1))
            seg = 0;
        else if (fl <= threshold(sel, 2))
            seg = 1;
        else if (fl <= threshold(sel, 3))
            seg = 2;
        else
            seg = 3;
        lo = threshold(sel, seg);
        hi = threshold(sel, seg + 1);
        lp = anchor(seg + 1);
        hp = anchor(seg + 2);
        if (hi <= lo)
        begin
            return 7'(lp);
        end
        return 7'(lp + ((fl - lo) * (hp - lp)) / (hi - lo));
    endfunction

    // UI percent update for a query word.
    function automatic void apply_query();
        logic [1:0] st;
        logic [6:0] pct;
        int         delta;
        int         v;
        st = charger_now();
        pct = floor_percent(st);
        if (!average_seen)
        begin
            return;
        end
        if (!ui_ready || st != ui_mode)
        begin
            ui_ready = 1'b1;
            ui_mode = st;
            ui_pct = pct;
            return;
        end
        if (st == CHG_MISSING)
        begin
            ui_pct = 7'd0;
            return;
        end
        if (st == CHG_FULL)
        begin
            ui_pct = pct;
            return;
        end
        delta = int'(pct) - int'(ui_pct);
        if (st == CHG_DISCHARGING && delta > 0)
        begin
            return;
        end
        if (delta >= int'(cfg_snap) || delta <= -int'(cfg_snap))
        begin
            ui_pct = pct;
            return;
        end
        v = int'(ui_pct);
        if (delta > 0)
            v = v + int'(cfg_step);
        else if (delta < 0)
            v = v - int'(cfg_step);
        if (v < 0)
            v = 0;
        if (v > 100)
            v = 100;
        ui_pct = 7'(v);
    endfunction

    // Advances the predicted state by one word and returns the reading it should give.
    function automatic gauge_reading_t predict_reading(input bcg_op_t op, input logic [15:0] smp,
                                                       input logic pg_lvl, input logic ch_lvl);
        gauge_reading_t r;
        int unsigned    win;
        int unsigned    avg;
        r = '0;
        case (op)
            OP_SAMPLE:
            begin
                if (settle_armed)
                begin
                    settle_armed = 1'b0;
                    r.restart = 1'b1;
                end
                else
                begin
                    win = (cfg_window == 4'd0) ? 1 : cfg_window;
                    window_sum = window_sum + smp;
                    window_count = window_count + 1;
                    if (window_count >= win)
                    begin
                        avg = (window_sum / window_count) & 32'hFFFF;
                        window_sum = 0;
                        window_count = 0;
                        last_average = avg[15:0];
                        if (!average_seen || avg[15:0] <= gauge_floor || floor_reseed)
                            gauge_floor = avg[15:0];
                        floor_reseed = 1'b0;
                        average_seen = 1'b1;
                        r.stop = 1'b1;
                    end
                end
            end
            OP_PINS:
            begin
                if (!pg_lvl != pg_flag || !ch_lvl != ch_flag)
                    floor_reseed = 1'b1;
                pg_flag = !pg_lvl;
                ch_flag = !ch_lvl;
            end
            OP_POLL:
            begin
                settle_armed = 1'b1;
            end
            OP_QUERY:
            begin
                apply_query();
            end
            default:
            begin
                r = '0;
            end
        endcase
        r.chg_state = charger_now();
        r.level = floor_percent(r.chg_state);
        r.ui = ui_pct;
        r.floor_lvl = gauge_floor;
        r.average = last_average;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Each result word is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        gauge_reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: result word arrived with none expected", $time);
            end
            else
            begin
                want = expected_readings.pop_front();
                compare_field("charger_state", want.chg_state, charger_state);
                compare_field("level_percent", want.level, level_percent);
                compare_field("ui_percent", want.ui, ui_percent);
                compare_field("floor_value", want.floor_lvl, floor_value);
                compare_field("window_average", want.average, window_average);
                compare_field("restart_conversion", want.restart, restart_conversion);
                compare_field("stop_conversion", want.stop, stop_conversion);
            end
        end
    end

    // Offers one word from a falling edge and returns at the falling edge after acceptance.
    task automatic send_word(input bcg_op_t op, input logic [15:0] smp, input logic pg_lvl,
                             input logic ch_lvl, input logic typed, input gauge_reading_t want);
        gauge_reading_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        adc_sample <= smp;
        pgood_pin <= pg_lvl;
        chg_pin <= ch_lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_reading(op, smp, pg_lvl, ch_lvl);
        expected_readings.push_back(typed ? want : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Holds the input side until every predicted word has been seen.
    task automatic wait_for_results(input logic settle);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes all four registers back to back; the block must be idle.
    task automatic write_settings(input logic [15:0] win, input logic [15:0] lim,
                                  input logic [15:0] snap, input logic [15:0] step);
        logic [15:0] vals [4];
        logic [1:0]  idx;
        vals[0] = win;
        vals[1] = lim;
        vals[2] = snap;
        vals[3] = step;
        for (int i = 0; i < 4; i++)
        begin
            idx = 2'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                REG_WINDOW_SAMPLES:   cfg_window = vals[i][3:0];
                REG_LOW_DOMAIN_LIMIT: cfg_limit = vals[i];
                REG_SNAP_THRESHOLD:   cfg_snap = vals[i][6:0];
                REG_STEP_SIZE:        cfg_step = vals[i][6:0];
                default:              cfg_window = cfg_window;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly a whole measurement: optional pin change, poll, settle sample,
    // one window of samples around a table region, then queries.
    task automatic run_burst();
        int unsigned win;
        logic [15:0] base;
        if ($urandom_range(0, 99) < 30)
        begin
            send_word(bcg_op_t'(2'($urandom_range(0, 3))), 16'($urandom), 1'($urandom),
                      1'($urandom), 1'b0, NO_CHECK);
            return;
        end
        win = (cfg_window == 4'd0) ? 1 : cfg_window;
        case ($urandom_range(0, 4))
            0, 1:    base = 16'h2900 + 16'($urandom_range(0, 16'h0900));
            2, 3:    base = 16'h8e00 + 16'($urandom_range(0, 16'h1e00));
            default: base = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            send_word(OP_PINS, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
        send_word(OP_POLL, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
        send_word(OP_SAMPLE, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
        repeat (win)
            send_word(OP_SAMPLE, base + 16'($urandom_range(0, 255)) - 16'h0080,
                      1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
        repeat ($urandom_range(1, 2))
            send_word(OP_QUERY, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
    endtask

    // Stimulus: directed table, then random phases under changing settings.
    initial
    begin : stimulus
        int unsigned phase_end;
        int unsigned mode;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_settings(16'd0, 16'h4000, 16'd5, 16'd1);
        for (int i = 0; i < PROBE_ROWS; i++)
            send_word(probe_table[i].op, probe_table[i].smp, probe_table[i].pg_pin,
                      probe_table[i].ch_pin, probe_table[i].typed, probe_table[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results(1'b1);
            case (p)
                0: begin write_settings(16'd15, 16'h4000, 16'd5, 16'd1); mode = 0; end
                1: begin write_settings(16'd1, 16'h0000, 16'd100, 16'd100); mode = 1; end
                2: begin write_settings(16'd3, 16'hFFFF, 16'd1, 16'd0); mode = 2; end
                3: begin write_settings(16'd2, 16'($urandom), 16'd127, 16'd127); mode = 3; end
                4: begin write_settings(16'd0, 16'h4000, 16'd0, 16'd3); mode = 2; end
                default:
                begin
                    write_settings(16'($urandom_range(1, 15)), 16'h4000,
                                   16'($urandom_range(1, 20)), 16'($urandom_range(1, 10)));
                    mode = 3;
                end
            endcase
            send_idle_pct = (mode == 1) ? 52 : (mode == 3) ? 31 : 0;
            stall_pct = (mode == 2) ? 52 : (mode == 3) ? 31 : 0;
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 3)
                    wait_for_results(1'b0);
                run_burst();
            end
            // Leave a part-filled window behind so the next setting meets it.
            repeat (3)
                send_word(OP_SAMPLE, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_CHECK);
        end

        wait_for_results(1'b1);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bcg_pkg.sv
rtl/core/bcg_front.sv
rtl/core/bcg_back.sv
rtl/core/battery_charge_gauge.sv
verif/tb_battery_charge_gauge.sv
